>>> sv/brfbf_pkg.sv
// Package for the byte ring FIFO block framer.
// Holds the sequencer state type, status codes, request kinds and the marker byte helper.
// Depends on nothing.
package brfbf_pkg;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WRITE,
      S_READ,
      S_READ_OUT,
      S_REPORT,
      S_HUNT,
      S_HUNT_CHK,
      S_MATCH,
      S_MATCH_CHK,
      S_SIZE,
      S_BLK,
      S_BLK_OUT
   } state_type;

   typedef logic [2:0] status_type;
   typedef logic [1:0] kind_type;

   localparam status_type ST_OK         = 3'd0;
   localparam status_type ST_FULL       = 3'd1;
   localparam status_type ST_EMPTY      = 3'd2;
   localparam status_type ST_ROOM_SHORT = 3'd3;
   localparam status_type ST_NO_MARKER  = 3'd4;
   localparam status_type ST_INCOMPLETE = 3'd5;

   localparam kind_type KIND_WRITE = 2'd0;
   localparam kind_type KIND_READ  = 2'd1;
   localparam kind_type KIND_BLOCK = 2'd2;

   localparam logic [7:0] SYNC_BYTE = 8'hE0;

   // Marker byte at position idx; position zero is always the sync byte.
   function automatic logic [7:0] marker_byte(input logic [23:0] tail, input logic [1:0] idx);
      logic [7:0] b;
      unique case (idx)
         2'd0: b = SYNC_BYTE;
         2'd1: b = tail[7:0];
         2'd2: b = tail[15:8];
         2'd3: b = tail[23:16];
         default: b = SYNC_BYTE;
      endcase
      return b;
   endfunction

endpackage

>>> sv/brfbf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Used for the ring storage of the byte ring FIFO block framer; no dependencies.
module brfbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/byte_ring_fifo_block_framer.sv
// Top level of the byte ring FIFO block framer: request sequencer, pointers and result register.
// Depends on brfbf_pkg and on brfbf_ram for the ring storage.
//
// Usage: requests arrive on the req_ stream, one transfer per request. req_tuser selects a byte
// write, a byte read or a framed block read. Each request yields one result transfer on the rsp_
// stream, except a block read that finds a complete block, which yields BLOCK_LEN transfers with
// rsp_tlast on the final one, and an unused kind, which yields none. Every result carries the
// fill level left after it. The marker tail is written through csr_we and csr_wdata; the user
// must do so only while idle; the block does not enforce it. The ring holds at most DEPTH-1
// bytes in one synchronous RAM with a registered read port. Requests are handled one at a time.
// A write passes through S_WRITE, a byte read through S_READ and S_READ_OUT. A block read visits
// S_HUNT and S_HUNT_CHK per byte discarded, S_MATCH and S_MATCH_CHK per byte compared, then
// S_BLK and S_BLK_OUT per emitted byte, as the single RAM read port is registered. The next
// request is accepted as soon as the last result is loaded into the output register, even while
// that result still waits to be taken. A stalled receiver holds the sequencer at its next
// result; nothing is lost or repeated. Reset clears both pointers, the marker tail and the output
// valid flag; the ring content needs no clearing as no byte is read before it is written.
module byte_ring_fifo_block_framer
   import brfbf_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int BLOCK_LEN  = 16,
   parameter int MARKER_LEN = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // write_data [7:0], room [23:8]
   input  logic [1:0]  req_tuser,   // kind [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_data [7:0], fill_level [15:8]
   output logic [2:0]  rsp_tuser,   // status [2:0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [23:0] csr_wdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = ($clog2(BLOCK_LEN) > 2) ? $clog2(BLOCK_LEN) : 2;

   state_type     state_ff, state_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] prb_ptr_ff, prb_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   status_type    status_ff, status_in;
   logic [7:0]    wdata_ff, wdata_in;
   logic [23:0]   tail_ff;

   logic          rsp_valid_ff;
   logic [7:0]    rsp_data_ff;
   logic [7:0]    rsp_fill_ff;
   status_type    rsp_status_ff;
   logic          rsp_last_ff;

   logic          accept;
   logic          out_free;
   logic          emit;
   logic [7:0]    emit_data;
   status_type    emit_status;
   logic          emit_last;
   logic [AW-1:0] held_cur;
   logic [AW-1:0] held_next;
   logic          ring_empty;
   logic          ring_full;
   logic          room_short;
   logic          ram_we;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;
   logic          marker_miss;
   kind_type      req_kind;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] held_of(input logic [AW-1:0] wr, input logic [AW-1:0] rd);
      logic [AW:0] diff;
      diff = {1'b0, wr} - {1'b0, rd};
      if (wr < rd) begin
         diff = diff + (AW+1)'(DEPTH);
      end
      return diff[AW-1:0];
   endfunction

   brfbf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_ptr_ff),
      .wdata (wdata_ff),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_kind    = req_tuser;
   assign accept      = req_tvalid && req_tready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign held_cur    = held_of(wr_ptr_ff, rd_ptr_ff);
   assign held_next   = held_of(wr_ptr_in, rd_ptr_in);
   assign ring_empty  = (rd_ptr_ff == wr_ptr_ff);
   assign ring_full   = (ptr_next(wr_ptr_ff) == rd_ptr_ff);
   assign room_short  = (req_tdata[23:8] < 16'(BLOCK_LEN));
   assign marker_miss = (ram_rdata != marker_byte(tail_ff, cnt_ff[1:0]));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_WRITE: state_in = ring_full ? S_REPORT : S_WRITE;
                  KIND_READ:  state_in = ring_empty ? S_REPORT : S_READ;
                  KIND_BLOCK: state_in = room_short ? S_REPORT : S_HUNT;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_WRITE, S_READ_OUT, S_REPORT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         S_READ: state_in = S_READ_OUT;
         S_HUNT: state_in = ring_empty ? S_REPORT : S_HUNT_CHK;
         S_HUNT_CHK: begin
            if (ram_rdata != SYNC_BYTE) begin
               state_in = S_HUNT;
            end else if (32'(held_cur) < MARKER_LEN) begin
               state_in = S_REPORT;
            end else if (MARKER_LEN == 1) begin
               state_in = S_SIZE;
            end else begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: state_in = S_MATCH_CHK;
         S_MATCH_CHK: begin
            if (marker_miss) begin
               state_in = S_HUNT;
            end else if (cnt_ff == CW'(MARKER_LEN - 1)) begin
               state_in = S_SIZE;
            end else begin
               state_in = S_MATCH;
            end
         end
         S_SIZE: state_in = (32'(held_cur) < BLOCK_LEN) ? S_REPORT : S_BLK;
         S_BLK:  state_in = S_BLK_OUT;
         S_BLK_OUT: begin
            if (out_free) begin
               state_in = (cnt_ff == CW'(BLOCK_LEN - 1)) ? S_IDLE : S_BLK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      prb_ptr_in = prb_ptr_ff;
      cnt_in     = cnt_ff;
      status_in  = status_ff;
      wdata_in   = wdata_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               wdata_in = req_tdata[7:0];
               case (req_kind)
                  KIND_WRITE: status_in = ST_FULL;
                  KIND_READ:  status_in = ST_EMPTY;
                  default:    status_in = ST_ROOM_SHORT;
               endcase
            end
         end
         S_WRITE: begin
            if (out_free) begin
               wr_ptr_in = ptr_next(wr_ptr_ff);
            end
         end
         S_READ_OUT: begin
            if (out_free) begin
               rd_ptr_in = ptr_next(rd_ptr_ff);
            end
         end
         S_HUNT: status_in = ST_NO_MARKER;
         S_HUNT_CHK: begin
            if (ram_rdata != SYNC_BYTE) begin
               rd_ptr_in = ptr_next(rd_ptr_ff);
            end else begin
               status_in  = ST_INCOMPLETE;
               prb_ptr_in = ptr_next(rd_ptr_ff);
               cnt_in     = CW'(1);
            end
         end
         S_MATCH_CHK: begin
            if (marker_miss) begin
               rd_ptr_in = ptr_next(rd_ptr_ff);
            end else begin
               cnt_in     = cnt_ff + 1'b1;
               prb_ptr_in = ptr_next(prb_ptr_ff);
            end
         end
         S_SIZE: begin
            status_in = ST_INCOMPLETE;
            cnt_in    = '0;
         end
         S_BLK_OUT: begin
            if (out_free) begin
               rd_ptr_in = ptr_next(rd_ptr_ff);
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      req_tready  = (state_ff == S_IDLE);
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      ram_raddr   = rd_ptr_ff;
      emit        = 1'b0;
      emit_data   = '0;
      emit_status = ST_OK;
      emit_last   = 1'b1;
      unique case (state_ff)
         S_WRITE: begin
            ram_we = out_free;
            emit   = 1'b1;
         end
         S_READ, S_HUNT, S_BLK: ram_re = 1'b1;
         S_MATCH: begin
            ram_re    = 1'b1;
            ram_raddr = prb_ptr_ff;
         end
         S_READ_OUT: begin
            emit      = 1'b1;
            emit_data = ram_rdata;
         end
         S_REPORT: begin
            emit        = 1'b1;
            emit_status = status_ff;
         end
         S_BLK_OUT: begin
            emit      = 1'b1;
            emit_data = ram_rdata;
            emit_last = (cnt_ff == CW'(BLOCK_LEN - 1));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         if (csr_we) begin
            tail_ff <= csr_wdata;
         end
         if (emit && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prb_ptr_ff <= prb_ptr_in;
      cnt_ff     <= cnt_in;
      status_ff  <= status_in;
      wdata_ff   <= wdata_in;
      if (emit && out_free) begin
         rsp_data_ff   <= emit_data;
         rsp_status_ff <= emit_status;
         rsp_last_ff   <= emit_last;
         rsp_fill_ff   <= 8'(held_next);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_fill_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      32'(rd_ptr_ff) < DEPTH && 32'(wr_ptr_ff) < DEPTH)
      else $error("ring pointer beyond depth");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ptr_next(wr_ptr_ff) != rd_ptr_ff)
      else $error("ring written while full");

   a_blk_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BLK_OUT && out_free) |-> rd_ptr_ff != wr_ptr_ff)
      else $error("block byte emitted from an empty ring");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_OK) |-> rsp_tlast)
      else $error("error status without last marking");

endmodule
